>>> hw/rtl/assert_macros.svh
// assertion macros used by the lexer result queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/slex_pkg.sv
// types, constants and helper functions of the s-expression lexer
`default_nettype none

package slex_pkg;

   // sizing of the text and position counters
   localparam int unsigned TEXT_BYTES     = 1048576;
   localparam int unsigned POSITION_LIMIT = 65535;

   localparam int unsigned POS_W = 16;
   localparam int unsigned OFF_W = 20;

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POSITION_LIMIT);
   localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(TEXT_BYTES - 1);

   // result queue sizing, depth kept a power of two so pointers wrap
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned RSP_DEPTH   = 4;
   localparam int unsigned RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   // byte codes with a meaning of their own
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_OPEN      = 8'h28;
   localparam logic [7:0] CHAR_CLOSE     = 8'h29;
   localparam logic [7:0] CHAR_SEMI      = 8'h3B;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_BAR       = 8'h7C;

   // keyword table: format, fun, sort, rule, lambda, arrow
   localparam int unsigned KW_COUNT = 6;
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd3, 3'd4, 3'd4, 3'd6, 3'd2};
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"f", "o", "r", "m", "a", "t", 8'h00, 8'h00},
      '{"f", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "o", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "u", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"l", "a", "m", "b", "d", "a", 8'h00, 8'h00},
      '{"-", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [KW_COUNT-1:0] KW_ALL = '1;

   typedef enum logic [4:0] {
      MODE_NORMAL  = 5'b00001,
      MODE_IDENT   = 5'b00010,
      MODE_COMMENT = 5'b00100,
      MODE_QUOTED  = 5'b01000,
      MODE_FAILED  = 5'b10000
   } mode_type;

   typedef enum logic [2:0] {
      ST_TOKEN    = 3'd0,
      ST_DONE     = 3'd1,
      ST_ILLEGAL  = 3'd2,
      ST_ESCAPE   = 3'd3,
      ST_UNCLOSED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      KIND_ID     = 4'd0,
      KIND_OPEN   = 4'd1,
      KIND_CLOSE  = 4'd2,
      KIND_FORMAT = 4'd3,
      KIND_FUN    = 4'd4,
      KIND_SORT   = 4'd5,
      KIND_RULE   = 4'd6,
      KIND_LAMBDA = 4'd7,
      KIND_ARROW  = 4'd8
   } kind_type;

   typedef struct packed {
      status_type       status;
      kind_type         token_kind;
      logic [POS_W-1:0] token_row;
      logic [POS_W-1:0] token_col;
      logic [OFF_W-1:0] token_offset;
      logic [POS_W-1:0] token_length;
      logic [7:0]       bad_byte;
      logic             last_of_run;
   } rsp_type;

   // one result slot offered to the queue
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

   // queue state seen by the top level
   typedef struct packed {
      logic valid;
      logic room;
   } queue_status_type;

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] v);
      return (v < POS_LIMIT) ? v + POS_W'(1) : POS_LIMIT;
   endfunction

   function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] v);
      return (v < OFF_LIMIT) ? v + OFF_W'(1) : OFF_LIMIT;
   endfunction

   function automatic logic ident_letter(input logic [7:0] c);
      logic hit;
      unique case (c) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
         "~", "!", "@", "$", "%", "^", "&", "*", "_", "-", "+", "=",
         "<", ">", ".", "?", "/": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // narrow the set of keywords still matching after byte c at position pos
   function automatic logic [KW_COUNT-1:0] kw_update(input logic [KW_COUNT-1:0] alive,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [7:0] c);
      logic [KW_COUNT-1:0] res;
      res = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (alive[k] && (pos < POS_W'(KW_LEN[k])) && (KW_TEXT[k][pos[2:0]] == c)) begin
            res[k] = 1'b1;
         end
      end
      return res;
   endfunction

   // first keyword whose whole text was matched, else a plain identifier
   function automatic kind_type ident_kind(input logic [KW_COUNT-1:0] alive,
                                           input logic [POS_W-1:0] len);
      kind_type kind;
      kind = KIND_ID;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (alive[k] && (len == POS_W'(KW_LEN[k]))) begin
            kind = kind_type'(4'(KIND_FORMAT) + 4'(k));
         end
      end
      return kind;
   endfunction

   function automatic rsp_type make_result(input status_type status,
                                           input kind_type kind,
                                           input logic [POS_W-1:0] row,
                                           input logic [POS_W-1:0] col,
                                           input logic [OFF_W-1:0] off,
                                           input logic [POS_W-1:0] len,
                                           input logic [7:0] bad);
      rsp_type r;
      r.status       = status;
      r.token_kind   = kind;
      r.token_row    = row;
      r.token_col    = col;
      r.token_offset = off;
      r.token_length = len;
      r.bad_byte     = bad;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/slex_core.sv
// lexer state registers and the per-byte step logic
`default_nettype none

module slex_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          char_byte,
   input  wire logic                end_of_text,
   output slex_pkg::push_type       slot [slex_pkg::MAX_RESULTS]
);

   slex_pkg::mode_type                 mode_ff, mode_in, mid_mode;
   logic [slex_pkg::POS_W-1:0]         row_ff, row_in, mid_row;
   logic [slex_pkg::POS_W-1:0]         col_ff, col_in, mid_col;
   logic [slex_pkg::OFF_W-1:0]         off_ff, off_in, mid_off;
   logic [slex_pkg::POS_W-1:0]         srow_ff, srow_in, mid_srow;
   logic [slex_pkg::POS_W-1:0]         scol_ff, scol_in, mid_scol;
   logic [slex_pkg::OFF_W-1:0]         soff_ff, soff_in, mid_soff;
   logic [slex_pkg::POS_W-1:0]         run_ff, run_in, mid_run;
   logic [slex_pkg::KW_COUNT-1:0]      alive_ff, alive_in, mid_alive;
   logic                               letter;
   logic                               run_normal;
   slex_pkg::push_type                 s0, s1, s2;

   assign letter = slex_pkg::ident_letter(char_byte);

   // one byte of lexing: slot 0 ends a pending identifier, slot 1 is what the byte
   // itself gives or an identifier closed by end of text, slot 2 is the end of text report
   always_comb begin
      mid_mode  = mode_ff;
      mid_row   = row_ff;
      mid_col   = col_ff;
      mid_srow  = srow_ff;
      mid_scol  = scol_ff;
      mid_soff  = soff_ff;
      mid_run   = run_ff;
      mid_alive = alive_ff;
      s0        = '0;
      s1        = '0;
      s2        = '0;
      run_normal = 1'b0;

      unique case (mode_ff)
         slex_pkg::MODE_NORMAL: begin
            run_normal = 1'b1;
         end
         slex_pkg::MODE_IDENT: begin
            if (letter) begin
               mid_alive = slex_pkg::kw_update(alive_ff, run_ff, char_byte);
               mid_run   = slex_pkg::pos_inc(run_ff);
               mid_col   = slex_pkg::pos_inc(col_ff);
            end else begin
               s0.valid = 1'b1;
               s0.data  = slex_pkg::make_result(slex_pkg::ST_TOKEN,
                             slex_pkg::ident_kind(alive_ff, run_ff),
                             srow_ff, scol_ff, soff_ff, run_ff, 8'h00);
               mid_mode   = slex_pkg::MODE_NORMAL;
               run_normal = 1'b1;
            end
         end
         slex_pkg::MODE_COMMENT: begin
            if (char_byte == slex_pkg::CHAR_NEWLINE) begin
               mid_row  = slex_pkg::pos_inc(row_ff);
               mid_col  = slex_pkg::POS_W'(1);
               mid_mode = slex_pkg::MODE_NORMAL;
            end
         end
         slex_pkg::MODE_QUOTED: begin
            if (char_byte == slex_pkg::CHAR_BAR) begin
               s1.valid = 1'b1;
               s1.data  = slex_pkg::make_result(slex_pkg::ST_TOKEN, slex_pkg::KIND_ID,
                             srow_ff, scol_ff, soff_ff, run_ff, 8'h00);
               mid_col  = slex_pkg::pos_inc(slex_pkg::pos_inc(col_ff));
               mid_mode = slex_pkg::MODE_NORMAL;
            end else if (char_byte == slex_pkg::CHAR_NEWLINE) begin
               mid_row = slex_pkg::pos_inc(row_ff);
               mid_col = '0;
               mid_run = slex_pkg::pos_inc(run_ff);
            end else begin
               mid_col = slex_pkg::pos_inc(col_ff);
               mid_run = slex_pkg::pos_inc(run_ff);
               if (char_byte == slex_pkg::CHAR_BACKSLASH) begin
                  s1.valid = 1'b1;
                  s1.data  = slex_pkg::make_result(slex_pkg::ST_ESCAPE, slex_pkg::KIND_ID,
                                row_ff, slex_pkg::pos_inc(col_ff), '0, '0, 8'h00);
                  mid_mode = slex_pkg::MODE_FAILED;
               end
            end
         end
         slex_pkg::MODE_FAILED: begin
         end
         default: begin
         end
      endcase

      // byte seen in normal mode, also after an identifier has just ended
      if (run_normal) begin
         unique case (char_byte) inside
            slex_pkg::CHAR_NEWLINE: begin
               mid_row = slex_pkg::pos_inc(row_ff);
               mid_col = slex_pkg::POS_W'(1);
            end
            slex_pkg::CHAR_SPACE, slex_pkg::CHAR_TAB: begin
               mid_col = slex_pkg::pos_inc(col_ff);
            end
            slex_pkg::CHAR_SEMI: begin
               mid_mode = slex_pkg::MODE_COMMENT;
            end
            slex_pkg::CHAR_BAR: begin
               mid_mode = slex_pkg::MODE_QUOTED;
               mid_srow = row_ff;
               mid_scol = col_ff;
               mid_soff = slex_pkg::off_inc(off_ff);
               mid_run  = '0;
            end
            slex_pkg::CHAR_OPEN, slex_pkg::CHAR_CLOSE: begin
               s1.valid = 1'b1;
               s1.data  = slex_pkg::make_result(slex_pkg::ST_TOKEN,
                             (char_byte == slex_pkg::CHAR_OPEN) ? slex_pkg::KIND_OPEN
                                                                : slex_pkg::KIND_CLOSE,
                             row_ff, col_ff, off_ff, slex_pkg::POS_W'(1), 8'h00);
               mid_col  = slex_pkg::pos_inc(col_ff);
            end
            default: begin
               if (letter) begin
                  mid_mode  = slex_pkg::MODE_IDENT;
                  mid_srow  = row_ff;
                  mid_scol  = col_ff;
                  mid_soff  = off_ff;
                  mid_run   = slex_pkg::POS_W'(1);
                  mid_alive = slex_pkg::kw_update(slex_pkg::KW_ALL, '0, char_byte);
                  mid_col   = slex_pkg::pos_inc(col_ff);
               end else begin
                  s1.valid = 1'b1;
                  s1.data  = slex_pkg::make_result(slex_pkg::ST_ILLEGAL, slex_pkg::KIND_ID,
                                row_ff, col_ff, '0, '0, char_byte);
                  mid_mode = slex_pkg::MODE_FAILED;
               end
            end
         endcase
      end

      mid_off = slex_pkg::off_inc(off_ff);

      // end of text: close what is open, report unless failed, and return to reset values
      if (end_of_text) begin
         unique case (mid_mode)
            slex_pkg::MODE_IDENT: begin
               s1.valid = 1'b1;
               s1.data  = slex_pkg::make_result(slex_pkg::ST_TOKEN,
                             slex_pkg::ident_kind(mid_alive, mid_run),
                             mid_srow, mid_scol, mid_soff, mid_run, 8'h00);
               s2.valid = 1'b1;
               s2.data  = slex_pkg::make_result(slex_pkg::ST_DONE, slex_pkg::KIND_ID,
                             '0, '0, '0, '0, 8'h00);
            end
            slex_pkg::MODE_QUOTED: begin
               s2.valid = 1'b1;
               s2.data  = slex_pkg::make_result(slex_pkg::ST_UNCLOSED, slex_pkg::KIND_ID,
                             mid_srow, mid_scol, '0, '0, 8'h00);
            end
            slex_pkg::MODE_FAILED: begin
            end
            default: begin
               s2.valid = 1'b1;
               s2.data  = slex_pkg::make_result(slex_pkg::ST_DONE, slex_pkg::KIND_ID,
                             '0, '0, '0, '0, 8'h00);
            end
         endcase
         mode_in  = slex_pkg::MODE_NORMAL;
         row_in   = slex_pkg::POS_W'(1);
         col_in   = slex_pkg::POS_W'(1);
         off_in   = '0;
         srow_in  = '0;
         scol_in  = '0;
         soff_in  = '0;
         run_in   = '0;
         alive_in = slex_pkg::KW_ALL;
      end else begin
         mode_in  = mid_mode;
         row_in   = mid_row;
         col_in   = mid_col;
         off_in   = mid_off;
         srow_in  = mid_srow;
         scol_in  = mid_scol;
         soff_in  = mid_soff;
         run_in   = mid_run;
         alive_in = mid_alive;
      end

      // mark the last result of this byte
      if (s2.valid) begin
         s2.data.last_of_run = 1'b1;
      end else if (s1.valid) begin
         s1.data.last_of_run = 1'b1;
      end else if (s0.valid) begin
         s0.data.last_of_run = 1'b1;
      end
   end

   assign slot[0] = s0;
   assign slot[1] = s1;
   assign slot[2] = s2;

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slex_pkg::MODE_NORMAL;
         row_ff   <= slex_pkg::POS_W'(1);
         col_ff   <= slex_pkg::POS_W'(1);
         off_ff   <= '0;
         srow_ff  <= '0;
         scol_ff  <= '0;
         soff_ff  <= '0;
         run_ff   <= '0;
         alive_ff <= slex_pkg::KW_ALL;
      end else if (step) begin
         mode_ff  <= mode_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         srow_ff  <= srow_in;
         scol_ff  <= scol_in;
         soff_ff  <= soff_in;
         run_ff   <= run_in;
         alive_ff <= alive_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/slex_rsp_queue.sv
// result queue taking up to three results per cycle and handing out one
`default_nettype none

`include "assert_macros.svh"

module slex_rsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire slex_pkg::push_type        push [slex_pkg::MAX_RESULTS],
   input  wire logic                      pop,
   output slex_pkg::rsp_type              head,
   output slex_pkg::queue_status_type     status
);

   slex_pkg::rsp_type                  entry_ff [slex_pkg::RSP_DEPTH];
   logic [slex_pkg::RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [slex_pkg::RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [slex_pkg::RSP_CNT_W-1:0]     count_ff, count_in;
   logic [slex_pkg::RSP_PTR_W-1:0]     wr_pos [slex_pkg::MAX_RESULTS];
   logic [1:0]                         push_total;
   logic                               last_pop;

   // compacted write positions of the valid slots
   always_comb begin
      wr_pos[0] = wr_ptr_ff;
      wr_pos[1] = wr_ptr_ff + slex_pkg::RSP_PTR_W'(push[0].valid);
      wr_pos[2] = wr_pos[1] + slex_pkg::RSP_PTR_W'(push[1].valid);
      push_total = 2'(push[0].valid) + 2'(push[1].valid) + 2'(push[2].valid);
   end

   assign wr_ptr_in = wr_ptr_ff + slex_pkg::RSP_PTR_W'(push_total);
   assign rd_ptr_in = rd_ptr_ff + slex_pkg::RSP_PTR_W'(pop);
   assign count_in  = count_ff + slex_pkg::RSP_CNT_W'(push_total)
                    - slex_pkg::RSP_CNT_W'(pop);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < slex_pkg::MAX_RESULTS; i++) begin
         if (push[i].valid) begin
            entry_ff[wr_pos[i]] <= push[i].data;
         end
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.room  = (count_ff <=
                          slex_pkg::RSP_CNT_W'(slex_pkg::RSP_DEPTH - slex_pkg::MAX_RESULTS));

   // last stored result leaves with nothing arriving
   assign last_pop = pop & (count_ff == slex_pkg::RSP_CNT_W'(1)) & (push_total == 2'd0);

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= slex_pkg::RSP_CNT_W'(slex_pkg::RSP_DEPTH))
   `ASSERT_IMPLIES(a_push_room, clock, reset, push_total != 2'd0, status.room)
   `ASSERT_NEXT(a_drain, clock, reset, last_pop, !status.valid)

endmodule

`default_nettype wire

>>> hw/rtl/sexpr_rule_file_lexer.sv
// top level of the s-expression rule-file lexer
// Usage:
//   Text enters one byte per req transaction (req_char_byte, with
//   req_end_of_text on the final byte). Each rsp transaction carries one
//   result: a token, the text-done report or an error; rsp_last_of_run marks
//   the last result caused by a byte, which may cause none, one, two or three.
//   An accepted byte waits in the input register until it is lexed; its
//   results are written into the result queue, and the first of them is
//   offered from the queue registers after that write.
//   Throughput is one byte per cycle while bytes give at most one result each
//   and the receiver keeps up; the lexing step waits while the four-entry
//   result queue holds more than one result, since a byte may push three.
//   When the receiver stalls, results stay in the queue and the input side
//   stalls once the input register holds a byte and the queue holds more
//   than one result; nothing is lost.
//   After a byte marked end_of_text the lexer returns to its reset state and
//   the next byte starts a new text. Reset empties the queue and the input
//   register and sets row and column to 1, offset to 0 and the mode to normal.
`default_nettype none

module sexpr_rule_file_lexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_row,
   output logic [15:0]      rsp_token_col,
   output logic [19:0]      rsp_token_offset,
   output logic [15:0]      rsp_token_length,
   output logic [7:0]       rsp_bad_byte,
   output logic             rsp_last_of_run
);

   logic                              in_valid_ff, in_valid_in;
   logic [7:0]                        in_byte_ff;
   logic                              in_eot_ff;
   logic                              accept;
   logic                              step;
   logic                              pop;
   slex_pkg::push_type                slot [slex_pkg::MAX_RESULTS];
   slex_pkg::push_type                push [slex_pkg::MAX_RESULTS];
   slex_pkg::rsp_type                 head;
   slex_pkg::queue_status_type        queue_status;

   // input register handshake
   assign step        = in_valid_ff & queue_status.room;
   assign req_stall   = in_valid_ff & ~queue_status.room;
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_char_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   slex_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .slot        (slot)
   );

   // results only enter the queue on a lexing step
   always_comb begin
      for (int i = 0; i < slex_pkg::MAX_RESULTS; i++) begin
         push[i].valid = slot[i].valid & step;
         push[i].data  = slot[i].data;
      end
   end

   assign pop = queue_status.valid & ~rsp_stall;

   slex_rsp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (queue_status)
   );

   // result ports
   assign rsp_valid        = queue_status.valid;
   assign rsp_status       = head.status;
   assign rsp_token_kind   = head.token_kind;
   assign rsp_token_row    = head.token_row;
   assign rsp_token_col    = head.token_col;
   assign rsp_token_offset = head.token_offset;
   assign rsp_token_length = head.token_length;
   assign rsp_bad_byte     = head.bad_byte;
   assign rsp_last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

>>> tb/sexpr_rule_file_lexer_checker.sv
// checker of the s-expression lexer: predicts every result and compares it with the block
`default_nettype none

module sexpr_rule_file_lexer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_text,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [3:0]  rsp_token_kind,
   input  wire logic [15:0] rsp_token_row,
   input  wire logic [15:0] rsp_token_col,
   input  wire logic [19:0] rsp_token_offset,
   input  wire logic [15:0] rsp_token_length,
   input  wire logic [7:0]  rsp_bad_byte,
   input  wire logic        rsp_last_of_run,
   output int               fail_count,
   output int               pending_count,
   output int               byte_count,
   output int               result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // lexer state as the predictor sees it
   slex_pkg::mode_type lex_mode;
   logic [15:0]        row_now;
   logic [15:0]        col_now;
   logic [19:0]        offset_now;
   logic [15:0]        tok_row;
   logic [15:0]        tok_col;
   logic [19:0]        tok_off;
   logic [15:0]        tok_len;
   logic [5:0]         kw_live;

   // results still owed by the block, oldest first
   slex_pkg::rsp_type  expected_q[$];
   slex_pkg::rsp_type  held;
   bit                 holding = 1'b0;
   int                 mismatches = 0;
   int                 bytes_seen = 0;
   int                 results_seen = 0;

   function automatic logic [15:0] bump_pos(input logic [15:0] v);
      return (v == slex_pkg::POS_LIMIT) ? v : v + 16'd1;
   endfunction

   function automatic logic [19:0] bump_off(input logic [19:0] v);
      return (v == slex_pkg::OFF_LIMIT) ? v : v + 20'd1;
   endfunction

   function automatic string kw_word(input int k);
      case (k)
         0: return "format";
         1: return "fun";
         2: return "sort";
         3: return "rule";
         4: return "lambda";
         default: return "->";
      endcase
   endfunction

   function automatic bit is_name_char(input logic [7:0] c);
      string extra;
      extra = "~!@$%^&*_-+=<>.?/";
      if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
         return 1'b1;
      end
      for (int i = 0; i < extra.len(); i++) begin
         if (extra[i] == c) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // keywords that still match once byte c sits at position pos
   function automatic logic [5:0] narrow_keywords(input logic [5:0] live,
                                                  input logic [15:0] pos,
                                                  input logic [7:0] c);
      logic [5:0] res;
      string      w;
      res = '0;
      for (int k = 0; k < 6; k++) begin
         w = kw_word(k);
         if (live[k] && pos < w.len()) begin
            if (w[pos] == c) begin
               res[k] = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic string describe(input slex_pkg::rsp_type r);
      return {$sformatf("status %0d kind %0d row %0d col %0d",
                        r.status, r.token_kind, r.token_row, r.token_col),
              $sformatf(" offset %0d length %0d bad %02h last %0b",
                        r.token_offset, r.token_length, r.bad_byte, r.last_of_run)};
   endfunction

   task automatic clear_state();
      lex_mode   = slex_pkg::MODE_NORMAL;
      row_now    = 16'd1;
      col_now    = 16'd1;
      offset_now = '0;
      tok_row    = '0;
      tok_col    = '0;
      tok_off    = '0;
      tok_len    = '0;
      kw_live    = '1;
   endtask

   // queue one result; the previous one is released as not last
   task automatic note(input slex_pkg::status_type st, input slex_pkg::kind_type kd,
                       input logic [15:0] r, input logic [15:0] c, input logic [19:0] o,
                       input logic [15:0] l, input logic [7:0] b);
      if (holding) begin
         expected_q.insert(expected_q.size(), held);
      end
      held.status       = st;
      held.token_kind   = kd;
      held.token_row    = r;
      held.token_col    = c;
      held.token_offset = o;
      held.token_length = l;
      held.bad_byte     = b;
      held.last_of_run  = 1'b0;
      holding = 1'b1;
   endtask

   // identifier or keyword token from the collected run
   task automatic note_word();
      slex_pkg::kind_type kd;
      string              w;
      kd = slex_pkg::KIND_ID;
      for (int k = 5; k >= 0; k--) begin
         w = kw_word(k);
         if (kw_live[k] && tok_len == w.len()) begin
            kd = slex_pkg::kind_type'(4'(slex_pkg::KIND_FORMAT) + 4'(k));
         end
      end
      note(slex_pkg::ST_TOKEN, kd, tok_row, tok_col, tok_off, tok_len, 8'h00);
   endtask

   // a byte seen in normal mode
   task automatic lex_plain(input logic [7:0] c);
      case (c)
         slex_pkg::CHAR_NEWLINE: begin
            row_now = bump_pos(row_now);
            col_now = 16'd1;
         end
         slex_pkg::CHAR_SPACE, slex_pkg::CHAR_TAB: begin
            col_now = bump_pos(col_now);
         end
         slex_pkg::CHAR_SEMI: begin
            lex_mode = slex_pkg::MODE_COMMENT;
         end
         slex_pkg::CHAR_BAR: begin
            lex_mode = slex_pkg::MODE_QUOTED;
            tok_row  = row_now;
            tok_col  = col_now;
            tok_off  = bump_off(offset_now);
            tok_len  = '0;
         end
         slex_pkg::CHAR_OPEN, slex_pkg::CHAR_CLOSE: begin
            note(slex_pkg::ST_TOKEN,
                 (c == slex_pkg::CHAR_OPEN) ? slex_pkg::KIND_OPEN : slex_pkg::KIND_CLOSE,
                 row_now, col_now, offset_now, 16'd1, 8'h00);
            col_now = bump_pos(col_now);
         end
         default: begin
            if (is_name_char(c)) begin
               lex_mode = slex_pkg::MODE_IDENT;
               tok_row  = row_now;
               tok_col  = col_now;
               tok_off  = offset_now;
               tok_len  = 16'd1;
               kw_live  = narrow_keywords('1, 16'd0, c);
               col_now  = bump_pos(col_now);
            end else begin
               note(slex_pkg::ST_ILLEGAL, slex_pkg::KIND_ID, row_now, col_now, '0, '0, c);
               lex_mode = slex_pkg::MODE_FAILED;
            end
         end
      endcase
   endtask

   // one accepted byte: advance the state and collect its results
   task automatic lex_byte(input logic [7:0] c, input logic eot);
      holding = 1'b0;
      case (lex_mode)
         slex_pkg::MODE_IDENT: begin
            if (is_name_char(c)) begin
               kw_live = narrow_keywords(kw_live, tok_len, c);
               tok_len = bump_pos(tok_len);
               col_now = bump_pos(col_now);
            end else begin
               note_word();
               lex_mode = slex_pkg::MODE_NORMAL;
               lex_plain(c);
            end
         end
         slex_pkg::MODE_NORMAL: begin
            lex_plain(c);
         end
         slex_pkg::MODE_COMMENT: begin
            if (c == slex_pkg::CHAR_NEWLINE) begin
               row_now  = bump_pos(row_now);
               col_now  = 16'd1;
               lex_mode = slex_pkg::MODE_NORMAL;
            end
         end
         slex_pkg::MODE_QUOTED: begin
            if (c == slex_pkg::CHAR_BAR) begin
               note(slex_pkg::ST_TOKEN, slex_pkg::KIND_ID, tok_row, tok_col, tok_off,
                    tok_len, 8'h00);
               col_now  = bump_pos(bump_pos(col_now));
               lex_mode = slex_pkg::MODE_NORMAL;
            end else if (c == slex_pkg::CHAR_NEWLINE) begin
               row_now = bump_pos(row_now);
               col_now = '0;
               tok_len = bump_pos(tok_len);
            end else begin
               col_now = bump_pos(col_now);
               tok_len = bump_pos(tok_len);
               if (c == slex_pkg::CHAR_BACKSLASH) begin
                  note(slex_pkg::ST_ESCAPE, slex_pkg::KIND_ID, row_now, col_now, '0, '0,
                       8'h00);
                  lex_mode = slex_pkg::MODE_FAILED;
               end
            end
         end
         default: ;
      endcase
      offset_now = bump_off(offset_now);

      // end of text closes what is open, then back to the start state
      if (eot) begin
         if (lex_mode == slex_pkg::MODE_IDENT) begin
            note_word();
            note(slex_pkg::ST_DONE, slex_pkg::KIND_ID, '0, '0, '0, '0, 8'h00);
         end else if (lex_mode == slex_pkg::MODE_QUOTED) begin
            note(slex_pkg::ST_UNCLOSED, slex_pkg::KIND_ID, tok_row, tok_col, '0, '0, 8'h00);
         end else if (lex_mode != slex_pkg::MODE_FAILED) begin
            note(slex_pkg::ST_DONE, slex_pkg::KIND_ID, '0, '0, '0, '0, 8'h00);
         end
         clear_state();
      end

      if (holding) begin
         held.last_of_run = 1'b1;
         expected_q.insert(expected_q.size(), held);
         holding = 1'b0;
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin : watch
      slex_pkg::rsp_type got;
      slex_pkg::rsp_type want;
      if (reset) begin
         clear_state();
         expected_q.delete();
      end else begin
         // input transaction
         if (req_valid && !req_stall) begin
            lex_byte(req_char_byte, req_end_of_text);
            bytes_seen++;
         end
         // result transaction
         if (rsp_valid && !rsp_stall) begin
            got.status       = slex_pkg::status_type'(rsp_status);
            got.token_kind   = slex_pkg::kind_type'(rsp_token_kind);
            got.token_row    = rsp_token_row;
            got.token_col    = rsp_token_col;
            got.token_offset = rsp_token_offset;
            got.token_length = rsp_token_length;
            got.bad_byte     = rsp_bad_byte;
            got.last_of_run  = rsp_last_of_run;
            results_seen++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result with nothing outstanding: %s",
                           $realtime, describe(got));
               end
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.token_kind !== want.token_kind ||
                   got.token_row !== want.token_row || got.token_col !== want.token_col ||
                   got.token_offset !== want.token_offset ||
                   got.token_length !== want.token_length ||
                   got.bad_byte !== want.bad_byte || got.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result %0d differs", $realtime, results_seen);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(got));
                  end
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
      byte_count    <= bytes_seen;
      result_count  <= results_seen;
   end

endmodule

`default_nettype wire

>>> tb/sexpr_rule_file_lexer_test.sv
// top of the lexer testbench: clock, reset, text stimulus and the verdict
`default_nettype none

module sexpr_rule_file_lexer_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_token_row;
   logic [15:0] rsp_token_col;
   logic [19:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic [7:0]  rsp_bad_byte;
   logic        rsp_last_of_run;

   int          fail_count;
   int          pending_count;
   int          byte_count;
   int          result_count;

   // no idling on either side while set
   bit          calm = 1'b0;
   logic [7:0]  text_q[$];
   int          random_bytes;
   string       name_pool = {"0123456789abcdefghijklmnopqrstuvwxyz",
                             "ABCDEFGHIJKLMNOPQRSTUVWXYZ~!@$%^&*_-+=<>.?/"};

   sexpr_rule_file_lexer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_row    (rsp_token_row),
      .rsp_token_col    (rsp_token_col),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_bad_byte     (rsp_bad_byte),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   sexpr_rule_file_lexer_checker watcher (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_row    (rsp_token_row),
      .rsp_token_col    (rsp_token_col),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_bad_byte     (rsp_bad_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .byte_count       (byte_count),
      .result_count     (result_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 28);
      end
   end

   // one byte, held until the block takes it
   task automatic send_byte(input logic [7:0] c, input logic eot);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   task automatic send_queue();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   // append one byte to the pending text
   task automatic add_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endtask

   function automatic logic [7:0] name_char();
      return name_pool[$urandom_range(name_pool.len() - 1)];
   endfunction

   // any byte that stays inside a quote
   function automatic logic [7:0] quote_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if ($urandom_range(7) == 0) begin
         c = slex_pkg::CHAR_NEWLINE;
      end else if (c == slex_pkg::CHAR_BAR || c == slex_pkg::CHAR_BACKSLASH) begin
         c = "q";
      end
      return c;
   endfunction

   // append one random lexical piece of text
   task automatic add_piece();
      int    pick;
      int    n;
      string w;
      pick = $urandom_range(99);
      if (pick < 14) begin
         add_byte($urandom_range(1) ? slex_pkg::CHAR_OPEN : slex_pkg::CHAR_CLOSE);
      end else if (pick < 30) begin
         // keywords, their prefixes and longer look-alikes
         case ($urandom_range(5))
            0: w = "format";
            1: w = "fun";
            2: w = "sort";
            3: w = "rule";
            4: w = "lambda";
            default: w = "->";
         endcase
         n = w.len();
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, w.len());
         end
         for (int i = 0; i < n; i++) begin
            add_byte(w[i]);
         end
         if ($urandom_range(4) == 0) begin
            add_byte(name_char());
         end
         case ($urandom_range(2))
            0: add_byte(slex_pkg::CHAR_SPACE);
            1: add_byte(slex_pkg::CHAR_NEWLINE);
            default: add_byte(slex_pkg::CHAR_CLOSE);
         endcase
      end else if (pick < 46) begin
         repeat ($urandom_range(1, 7)) add_byte(name_char());
      end else if (pick < 60) begin
         case ($urandom_range(2))
            0: add_byte(slex_pkg::CHAR_SPACE);
            1: add_byte(slex_pkg::CHAR_TAB);
            default: add_byte(slex_pkg::CHAR_NEWLINE);
         endcase
      end else if (pick < 74) begin
         add_byte(slex_pkg::CHAR_BAR);
         repeat ($urandom_range(6)) add_byte(quote_char());
         add_byte(slex_pkg::CHAR_BAR);
      end else if (pick < 84) begin
         // comment body may hold any byte but a newline
         add_byte(slex_pkg::CHAR_SEMI);
         repeat ($urandom_range(6)) begin
            n = $urandom_range(255);
            add_byte((n == slex_pkg::CHAR_NEWLINE) ? slex_pkg::CHAR_BAR : 8'(n));
         end
         add_byte(slex_pkg::CHAR_NEWLINE);
      end else if (pick < 92) begin
         add_byte(8'($urandom_range(255)));
      end else begin
         // broken quote: a backslash inside, or never closed
         add_byte(slex_pkg::CHAR_BAR);
         repeat ($urandom_range(4)) add_byte(quote_char());
         if ($urandom_range(1)) begin
            add_byte(slex_pkg::CHAR_BACKSLASH);
            repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // stimulus
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed texts
      send_text("(format fun)");
      send_text("sort rule\tlambda ->;x y(\n formats lambd - |a\nb| ||");
      send_text("ab(");
      send_text("rule");
      send_text("(|open");
      send_text("|a\\b)");
      send_text("x#(");
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h41, 1'b1);
      send_text(" ");
      send_text(";abc");

      // random texts, mostly well formed
      random_bytes = 0;
      while (random_bytes < 70) begin
         calm <= (random_bytes >= 20 && random_bytes < 50);
         repeat ($urandom_range(1, 8)) add_piece();
         random_bytes += text_q.size();
         send_queue();
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("lexed %0d bytes and checked %0d results", byte_count, result_count);
      $display("texts covered keywords and look-alikes, quoting, comments and every error kind");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
